// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;
  localparam int   QDEPTH     = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] ROUND_K = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- rtl/sha_if.sv -----
interface sha_in_if;
  logic                 valid;
  logic                 ready;
  sha_pkg::req_t        payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- rtl/sha_queue.sv -----
module sha_queue #(
  parameter int DEPTH = sha_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sha_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sha_pkg::req_t out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_pkg::req_t   mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign in_ready  = (cnt_r != (AW+1)'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ----- rtl/sha_core.sv -----
module sha_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  sha_pkg::req_t req,
  sha_out_if.source     res
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PADZ = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_RND  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;

  logic [3:0]          st_r;
  logic [7:0]          wd;
  logic                we;
  logic [6:0]          nb_r;
  logic [63:0]         cnt_r;
  logic [63:0]         bitlen_r;
  logic                fin_r;
  logic                emit_r;
  sha_pkg::hash_t      h_r;
  logic [31:0]         a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [15:0][31:0]   w_r;
  logic [5:0]          rnd_r;
  logic [2:0]          idx_r;
  logic [31:0]         s0, s1, wn, t1, t2, big0, big1, ch, mj, wcur;

  assign req_ready = (st_r == S_IDLE);

  always_comb begin
    we = 1'b0;
    wd = req.data_byte;
    if (st_r == S_IDLE && req_valid) begin
      we = 1'b1;
      wd = (req.req_type == sha_pkg::REQ_FINISH) ? 8'h80 : req.data_byte;
    end else if (st_r == S_PADZ) begin
      we = 1'b1;
      wd = 8'h00;
    end else if (st_r == S_LEN) begin
      we = 1'b1;
      wd = bitlen_r[63:56];
    end
  end

  assign wcur  = w_r[0];
  assign s0    = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn    = w_r[0] + s0 + w_r[9] + s1;
  assign big1  = sha_pkg::rotr(e_r, 6) ^ sha_pkg::rotr(e_r, 11) ^ sha_pkg::rotr(e_r, 25);
  assign ch    = (e_r & f_r) ^ (~e_r & g_r);
  assign t1    = hh_r + big1 + ch + sha_pkg::ROUND_K[rnd_r] + wcur;
  assign big0  = sha_pkg::rotr(a_r, 2) ^ sha_pkg::rotr(a_r, 13) ^ sha_pkg::rotr(a_r, 22);
  assign mj    = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
  assign t2    = big0 + mj;

  assign res.valid       = (st_r == S_EMIT);
  assign res.digest_word = h_r[idx_r];
  assign res.word_index  = idx_r;
  assign res.last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      nb_r   <= '0;
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      emit_r <= 1'b0;
      h_r    <= sha_pkg::H_INIT;
      idx_r  <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == sha_pkg::REQ_APPEND) begin
              cnt_r <= cnt_r + 64'd1;
              if (nb_r == 7'd63) begin
                nb_r  <= '0;
                fin_r <= 1'b0;
                {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
                {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
                rnd_r <= '0;
                st_r  <= S_RND;
              end else begin
                nb_r <= nb_r + 7'd1;
              end
            end else begin
              bitlen_r <= {cnt_r[60:0], 3'b000};
              fin_r    <= 1'b1;
              if (nb_r == 7'd63) begin
                nb_r <= '0;
                {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
                {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
                rnd_r <= '0;
                st_r  <= S_RND;
              end else if (nb_r == 7'd55) begin
                nb_r <= nb_r + 7'd1;
                st_r <= S_LEN;
              end else begin
                nb_r <= nb_r + 7'd1;
                st_r <= S_PADZ;
              end
            end
          end
        end
        S_PADZ: begin
          if (nb_r == 7'd63) begin
            nb_r <= '0;
            {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
            {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
            rnd_r <= '0;
            st_r  <= S_RND;
          end else if (nb_r == 7'd55) begin
            nb_r <= nb_r + 7'd1;
            st_r <= S_LEN;
          end else begin
            nb_r <= nb_r + 7'd1;
          end
        end
        S_LEN: begin
          bitlen_r <= {bitlen_r[55:0], 8'h00};
          if (nb_r == 7'd63) begin
            nb_r   <= '0;
            fin_r  <= 1'b0;
            emit_r <= 1'b1;
            {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
            {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
            rnd_r <= '0;
            st_r  <= S_RND;
          end else begin
            nb_r <= nb_r + 7'd1;
          end
        end
        S_RND: begin
          w_r   <= {wn, w_r[15:1]};
          hh_r  <= g_r;
          g_r   <= f_r;
          f_r   <= e_r;
          e_r   <= d_r + t1;
          d_r   <= c_r;
          c_r   <= b_r;
          b_r   <= a_r;
          a_r   <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            st_r <= S_ADD;
          end
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          h_r[5] <= h_r[5] + f_r;
          h_r[6] <= h_r[6] + g_r;
          h_r[7] <= h_r[7] + hh_r;
          if (fin_r) begin
            st_r <= S_PADZ;
          end else if (emit_r) begin
            emit_r <= 1'b0;
            st_r   <= S_EMIT;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (res.ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              h_r   <= sha_pkg::H_INIT;
              cnt_r <= '0;
              nb_r  <= '0;
              st_r  <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if (we) begin
        w_r[nb_r[5:2]][{~nb_r[1:0], 3'b000} +: 8] <= wd;
      end
    end
  end
endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream. Append transactions write one byte each into the
// block buffer; the 64th byte of a block starts a compression (the rounds, then
// an add into the hash state), during which transactions wait in a queue of
// QUEUE_DEPTH entries (four by default). A finish transaction pads the rest of
// the block (and a whole second block when fewer than nine bytes remain), runs the
// final compression, then presents the eight digest words in order, one per cycle
// while the output is taken. After the last word the block starts a new message.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher #(
  parameter int QUEUE_DEPTH = sha_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);
  logic          q_valid, q_ready;
  sha_pkg::req_t q_data;
  logic          out_fire;
  logic          out_last;

  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.payload),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (q_data),
    .res       (out_ch)
  );

  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_last = out_ch.valid && out_ch.last_word;

  `SHA_ASSERT_IMPL(a_last_idx, clk, rst_n, out_last, out_ch.word_index == 3'd7)
  `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n, out_fire && !out_ch.last_word, out_ch.valid)
  `SHA_ASSERT_IMPL(a_no_take, clk, rst_n, out_ch.valid, !q_ready)
endmodule
